@@ src/slcs_pkg.sv @@
// ============================================================================
// slcs_pkg
// Shared types, codes and helpers for the supply level cycling sequencer.
// ============================================================================
`timescale 1ns / 1ps

package slcs_pkg;

    // Level table geometry and timer limits
    localparam int unsigned LEVEL_DEPTH = 16;
    localparam int unsigned TIMER_W     = 26;
    localparam int unsigned TMO_W       = 22;
    localparam int unsigned MS_PER_S    = 1000;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_SWON_TMO    = 2'd1;
    localparam logic [1:0] CFG_MOVE_TMO    = 2'd2;
    localparam logic [1:0] CFG_SHUT_TMO    = 2'd3;

    localparam logic [4:0]       RST_LEVEL_COUNT = 5'd0;
    localparam logic [TMO_W-1:0] RST_SWON_TMO    = 22'd1400000;
    localparam logic [TMO_W-1:0] RST_MOVE_TMO    = 22'd280000;
    localparam logic [TMO_W-1:0] RST_SHUT_TMO    = 22'd1400000;

    // Event codes carried in the mode field
    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_LOAD      = 4'd1;
    localparam logic [3:0] MODE_CONFIGURE = 4'd2;
    localparam logic [3:0] MODE_STARTUP   = 4'd3;
    localparam logic [3:0] MODE_CYCLE     = 4'd4;
    localparam logic [3:0] MODE_SHUTDOWN  = 4'd5;
    localparam logic [3:0] MODE_INTERRUPT = 4'd6;
    localparam logic [3:0] MODE_CONTINUE  = 4'd7;
    localparam logic [3:0] MODE_ONTARGET  = 4'd8;
    localparam logic [3:0] MODE_OFF       = 4'd9;
    localparam logic [3:0] MODE_CTRLERROR = 4'd10;
    localparam logic [3:0] MODE_DEMAND    = 4'd11;

    // Controller command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_CONF  = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_SET   = 3'd3;
    localparam logic [2:0] CMD_SHUT  = 3'd4;
    localparam logic [2:0] CMD_INTR  = 3'd5;

    // Reported phase codes
    localparam logic [2:0] PHASE_IDLE  = 3'd0;
    localparam logic [2:0] PHASE_SWON  = 3'd1;
    localparam logic [2:0] PHASE_MOVE  = 3'd2;
    localparam logic [2:0] PHASE_DWELL = 3'd3;
    localparam logic [2:0] PHASE_SHUT  = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_LINK   = 3'd1;
    localparam logic [2:0] ERR_NO_LEVELS = 3'd2;
    localparam logic [2:0] ERR_SWON_TMO  = 3'd3;
    localparam logic [2:0] ERR_MOVE_TMO  = 3'd4;
    localparam logic [2:0] ERR_SHUT_TMO  = 3'd5;
    localparam logic [2:0] ERR_NO_STEP   = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWON  = 5'b00010,
        ST_MOVE  = 5'b00100,
        ST_DWELL = 5'b01000,
        ST_SHUT  = 5'b10000
    } state_t;

    typedef struct packed {
        state_t             state;
        logic [4:0]         pointer;
        logic [TIMER_W-1:0] timer;
    } seq_state_t;

    typedef struct packed {
        logic [4:0]       level_count;
        logic [TMO_W-1:0] swon_tmo;
        logic [TMO_W-1:0] move_tmo;
        logic [TMO_W-1:0] shut_tmo;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sp_first;   // setpoint of level 0
        logic [15:0] sp_next;    // setpoint of level pointer + 1
        logic [15:0] dwell_cur;  // dwell of level pointer
    } table_rd_t;

    typedef struct packed {
        logic [2:0]  ctrl_command;
        logic [15:0] ctrl_setpoint;
        logic [2:0]  phase;
        logic [4:0]  current_level;
        logic        run_started;
        logic        run_finished;
        logic        shutdown_done;
        logic        run_interrupted;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic [2:0] phase_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_SWON:  code = PHASE_SWON;
            ST_MOVE:  code = PHASE_MOVE;
            ST_DWELL: code = PHASE_DWELL;
            ST_SHUT:  code = PHASE_SHUT;
            default:  code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ src/slcs_step.sv @@
// ============================================================================
// slcs_step
// Next-state and result logic for one event of the level sequencer.
// ============================================================================
`timescale 1ns / 1ps

module slcs_step
    import slcs_pkg::*;
(
    input  logic [3:0] mode,
    input  logic       link_up,
    input  seq_state_t cur,
    input  cfg_t       cfg,
    input  table_rd_t  rd,
    output seq_state_t nxt,
    output result_t    res,
    output logic       load_en
);

    logic [4:0]         n_levels;
    logic               in_run;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] limit;
    logic [TIMER_W-1:0] dwell_ms;
    logic [4:0]         ptr_inc;

    assign n_levels = (cfg.level_count > 5'(LEVEL_DEPTH)) ? 5'(LEVEL_DEPTH) : cfg.level_count;
    assign in_run   = (cur.state == ST_SWON) || (cur.state == ST_MOVE)
                   || (cur.state == ST_DWELL);
    assign timer_inc = (cur.timer == TIMER_MAX) ? cur.timer : cur.timer + TIMER_W'(1);
    assign ptr_inc   = cur.pointer + 5'd1;
    assign dwell_ms  = (cur.pointer < n_levels)
                     ? TIMER_W'(rd.dwell_cur) * TIMER_W'(MS_PER_S) : '0;

    always_comb
    begin
        case (cur.state)
            ST_SWON: limit = TIMER_W'(cfg.swon_tmo);
            ST_MOVE: limit = TIMER_W'(cfg.move_tmo);
            ST_SHUT: limit = TIMER_W'(cfg.shut_tmo);
            default: limit = dwell_ms;
        endcase
    end

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        load_en = 1'b0;

        if ((mode >= MODE_STARTUP) && (mode <= MODE_CONTINUE) && !link_up)
        begin
            res.error_code = ERR_NO_LINK;
            nxt.state      = ST_IDLE;
        end
        else
        begin
            case (mode)
                MODE_TICK:
                begin
                    if (cur.state != ST_IDLE)
                    begin
                        nxt.timer = timer_inc;
                        if (timer_inc >= limit)
                        begin
                            case (cur.state)
                                ST_SWON:
                                begin
                                    res.error_code = ERR_SWON_TMO;
                                    nxt.state      = ST_IDLE;
                                end
                                ST_MOVE:
                                begin
                                    res.error_code = ERR_MOVE_TMO;
                                    nxt.state      = ST_IDLE;
                                end
                                ST_SHUT:
                                begin
                                    res.error_code = ERR_SHUT_TMO;
                                    nxt.state      = ST_IDLE;
                                end
                                default:
                                begin
                                    // dwell over: step on, finish the run, or report a missing step
                                    if ((n_levels == 5'd0) || (cur.pointer >= n_levels))
                                    begin
                                        res.error_code = ERR_NO_STEP;
                                        nxt.state      = ST_IDLE;
                                    end
                                    else
                                    begin
                                        nxt.pointer = ptr_inc;
                                        if (ptr_inc < n_levels)
                                        begin
                                            res.ctrl_command  = CMD_SET;
                                            res.ctrl_setpoint = rd.sp_next;
                                            nxt.state         = ST_MOVE;
                                            nxt.timer         = '0;
                                        end
                                        else
                                        begin
                                            res.run_finished = 1'b1;
                                            nxt.state        = ST_IDLE;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
                MODE_LOAD:
                begin
                    load_en = 1'b1;
                end
                MODE_CONFIGURE:
                begin
                    nxt.state = ST_IDLE;
                    if (n_levels != 5'd0)
                    begin
                        nxt.pointer       = 5'd0;
                        res.ctrl_command  = CMD_CONF;
                        res.ctrl_setpoint = rd.sp_first;
                    end
                    else
                    begin
                        res.error_code = ERR_NO_LEVELS;
                    end
                end
                MODE_STARTUP, MODE_CYCLE:
                begin
                    if (n_levels == 5'd0)
                    begin
                        res.error_code = ERR_NO_LEVELS;
                        nxt.state      = ST_IDLE;
                    end
                    else
                    begin
                        nxt.pointer     = 5'd0;
                        nxt.timer       = '0;
                        res.run_started = 1'b1;
                        if (mode == MODE_STARTUP)
                        begin
                            res.ctrl_command = CMD_START;
                            nxt.state        = ST_SWON;
                        end
                        else
                        begin
                            res.ctrl_command  = CMD_SET;
                            res.ctrl_setpoint = rd.sp_first;
                            nxt.state         = ST_MOVE;
                        end
                    end
                end
                MODE_SHUTDOWN:
                begin
                    res.run_interrupted = in_run;
                    res.ctrl_command    = CMD_SHUT;
                    nxt.state           = ST_SHUT;
                    nxt.timer           = '0;
                end
                MODE_INTERRUPT:
                begin
                    res.run_interrupted = in_run;
                    res.ctrl_command    = CMD_INTR;
                    nxt.state           = ST_IDLE;
                end
                MODE_CONTINUE:
                begin
                    nxt.state = ST_DWELL;
                    nxt.timer = '0;
                end
                MODE_ONTARGET:
                begin
                    if ((cur.state == ST_SWON) || (cur.state == ST_MOVE))
                    begin
                        nxt.state = ST_DWELL;
                        nxt.timer = '0;
                    end
                end
                MODE_OFF:
                begin
                    if (cur.state == ST_SHUT)
                    begin
                        res.shutdown_done = 1'b1;
                        nxt.state         = ST_IDLE;
                    end
                end
                MODE_CTRLERROR:
                begin
                    res.run_interrupted = in_run;
                    nxt.state           = ST_IDLE;
                end
                MODE_DEMAND:
                begin
                    if (n_levels != 5'd0)
                    begin
                        res.ctrl_command  = CMD_CONF;
                        res.ctrl_setpoint = rd.sp_first;
                    end
                    else
                    begin
                        res.error_code = ERR_NO_LEVELS;
                    end
                end
                default:
                begin
                    // unused event codes: drop
                end
            endcase
        end

        res.phase         = phase_code(nxt.state);
        res.current_level = nxt.pointer;
    end

endmodule

@@ src/supply_level_cycling_sequencer.sv @@
// ============================================================================
// supply_level_cycling_sequencer
// Walks a magnet supply through a table of setpoint/dwell levels.
// ============================================================================
//
//  Channel   Handshake            Payload                       Dir
//  -------   ------------------   ---------------------------   ---
//  event     in_valid/in_ready    mode, link_up, entry_*        in
//  result    out_valid/out_ready  ctrl_*, phase, level, flags   out
//  config    cfg_we               cfg_index, cfg_data           in
//
//  Throughput is one word per clock while out_ready is high; a word passes the
//  input register, the single step of event logic and the result register.
//  Reset idles the sequencer and loads the default timeouts; the level table
//  holds no reset value and needs no clearing pass.
//  With out_ready low the result register holds and the input register still
//  takes one more word before in_ready drops.
//
`timescale 1ns / 1ps

module supply_level_cycling_sequencer
    import slcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        mode,
    input  logic              link_up,
    input  logic [3:0]        entry_index,
    input  logic [15:0]       entry_setpoint,
    input  logic [15:0]       entry_dwell_s,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        ctrl_command,
    output logic [15:0]       ctrl_setpoint,
    output logic [2:0]        phase,
    output logic [4:0]        current_level,
    output logic              run_started,
    output logic              run_finished,
    output logic              shutdown_done,
    output logic              run_interrupted,
    output logic [2:0]        error_code,

    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TMO_W-1:0]  cfg_data
);

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [3:0]  mode_reg;
    logic        link_reg;
    logic [3:0]  index_reg;
    logic [15:0] setpoint_reg;
    logic [15:0] dwell_reg;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;

    // Sequencer state and configuration
    seq_state_t  state_reg;
    seq_state_t  state_next;
    cfg_t        cfg_reg;

    // Level table, written by load words only
    logic [15:0] setpoints_reg [LEVEL_DEPTH];
    logic [15:0] dwells_reg    [LEVEL_DEPTH];

    table_rd_t   table_rd;
    result_t     step_res;
    logic        load_en;
    logic        advance;
    logic        in_take;

    // Move the held word into the result register whenever that slot frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Table reads: level 0, the current level and the one after it.
    assign table_rd.sp_first  = setpoints_reg[0];
    assign table_rd.sp_next   = setpoints_reg[state_reg.pointer[3:0] + 4'd1];
    assign table_rd.dwell_cur = dwells_reg[state_reg.pointer[3:0]];

    slcs_step u_step
    (
        .mode    (mode_reg),
        .link_up (link_reg),
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .rd      (table_rd),
        .nxt     (state_next),
        .res     (step_res),
        .load_en (load_en)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{state: ST_IDLE, pointer: 5'd0, timer: '0};
            cfg_reg       <= '{level_count: RST_LEVEL_COUNT, swon_tmo: RST_SWON_TMO,
                               move_tmo: RST_MOVE_TMO, shut_tmo: RST_SHUT_TMO};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVEL_COUNT: cfg_reg.level_count <= cfg_data[4:0];
                    CFG_SWON_TMO:    cfg_reg.swon_tmo    <= cfg_data;
                    CFG_MOVE_TMO:    cfg_reg.move_tmo    <= cfg_data;
                    CFG_SHUT_TMO:    cfg_reg.shut_tmo    <= cfg_data;
                    default:         cfg_reg             <= cfg_reg;
                endcase
            end
        end
    end

    // Payload: capture the event word, the result and table writes.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg     <= mode;
            link_reg     <= link_up;
            index_reg    <= entry_index;
            setpoint_reg <= entry_setpoint;
            dwell_reg    <= entry_dwell_s;
        end
        if (advance)
        begin
            result_reg <= step_res;
            if (load_en)
            begin
                setpoints_reg[index_reg] <= setpoint_reg;
                dwells_reg[index_reg]    <= dwell_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign ctrl_command    = result_reg.ctrl_command;
    assign ctrl_setpoint   = result_reg.ctrl_setpoint;
    assign phase           = result_reg.phase;
    assign current_level   = result_reg.current_level;
    assign run_started     = result_reg.run_started;
    assign run_finished    = result_reg.run_finished;
    assign shutdown_done   = result_reg.shutdown_done;
    assign run_interrupted = result_reg.run_interrupted;
    assign error_code      = result_reg.error_code;

endmodule

@@ src/slcs_checker.sv @@
// ============================================================================
// slcs_checker
// Port-level checks on the result stream of the level sequencer.
// ============================================================================
`timescale 1ns / 1ps

module slcs_checker
    import slcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  ctrl_command,
    input logic [15:0] ctrl_setpoint,
    input logic [2:0]  phase,
    input logic [4:0]  current_level,
    input logic        run_started,
    input logic        run_finished,
    input logic [2:0]  error_code
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ctrl_command)
            && $stable(ctrl_setpoint) && $stable(phase) && $stable(error_code))
        else $error("result changed while stalled");

    // A start always restarts from level 0 with a start or set command
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_started |-> current_level == 5'd0
            && (ctrl_command == CMD_START || ctrl_command == CMD_SET))
        else $error("run start without proper command");

    // Every error other than the missing-levels case drops back to idle
    a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE && error_code != ERR_NO_LEVELS
            |-> phase == PHASE_IDLE)
        else $error("error left sequencer active");

    // A finished run is idle past level 0 and sends nothing
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_finished |-> phase == PHASE_IDLE
            && ctrl_command == CMD_NONE && current_level != 5'd0)
        else $error("bad finish report");

    // Setpoint only travels with configure or set level
    a_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ctrl_command != CMD_CONF && ctrl_command != CMD_SET
            |-> ctrl_setpoint == 16'd0)
        else $error("setpoint without a setpoint command");

endmodule

bind supply_level_cycling_sequencer slcs_checker u_slcs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ctrl_command  (ctrl_command),
    .ctrl_setpoint (ctrl_setpoint),
    .phase         (phase),
    .current_level (current_level),
    .run_started   (run_started),
    .run_finished  (run_finished),
    .error_code    (error_code)
);
